// ===== hw/rtl/rlpg_pkg.sv =====
// Package for the RGB LED pattern generator: request/response structs,
// mode codes, register indexes and the green-from-brightness function.
// No dependencies.
package rlpg_pkg;

   localparam int unsigned LevelWidth  = 8;
   localparam int unsigned PeriodWidth = 16;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [LevelWidth-1:0] LevelMax = 8'd255;
   localparam logic [LevelWidth-1:0] LevelOff = 8'd0;

   // floor(x*17/20) as (x * 55709) >> 16, with 55709 near 17/20 * 2^16, exact for 8-bit x
   localparam logic [15:0] GreenRecip = 16'd55709;

   typedef enum logic [2:0] {
      MODE_YELLOW = 3'd0,
      MODE_POLICE = 3'd1,
      MODE_RED    = 3'd2,
      MODE_GREEN  = 3'd3,
      MODE_BLUE   = 3'd4,
      MODE_CYCLE  = 3'd5
   } mode_type;

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_MODE = 1'b1
   } action_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PULSE_PERIOD = 2'd0,
      CSR_FLASH_PERIOD = 2'd1,
      CSR_CYCLE_PERIOD = 2'd2
   } csr_index_type;

   localparam logic [PeriodWidth-1:0] PulsePeriodReset = 16'd10;
   localparam logic [PeriodWidth-1:0] FlashPeriodReset = 16'd500;
   localparam logic [PeriodWidth-1:0] CyclePeriodReset = 16'd1000;

   typedef struct packed {
      logic       action;
      logic [2:0] new_mode;
   } req_type;

   typedef struct packed {
      logic [LevelWidth-1:0] red_level;
      logic [LevelWidth-1:0] green_level;
      logic [LevelWidth-1:0] blue_level;
      logic [2:0]            mode_now;
   } rsp_type;

   typedef struct packed {
      logic [PeriodWidth-1:0] pulse_period;
      logic [PeriodWidth-1:0] flash_period;
      logic [PeriodWidth-1:0] cycle_period;
   } cfg_type;

   function automatic logic [LevelWidth-1:0] green_of(input logic [LevelWidth-1:0] level);
      logic [LevelWidth+15:0] prod;
      prod = {16'd0, level} * {{LevelWidth{1'b0}}, GreenRecip};
      return prod[LevelWidth+15:16];
   endfunction

endpackage

// ===== hw/rtl/rlpg_engine.sv =====
// Pattern state and next-state logic for the RGB LED pattern generator.
// Depends on rlpg_pkg.
module rlpg_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  rlpg_pkg::req_type req,
   input  rlpg_pkg::cfg_type cfg,
   output rlpg_pkg::rsp_type result
);
   import rlpg_pkg::*;

   logic [TimeWidth-1:0]  now_ff, now_in;
   logic [TimeWidth-1:0]  pulse_ts_ff, pulse_ts_in;
   logic [TimeWidth-1:0]  flash_ts_ff, flash_ts_in;
   logic [TimeWidth-1:0]  cycle_ts_ff, cycle_ts_in;
   mode_type              mode_ff, mode_in;
   logic [LevelWidth-1:0] fade_ff, fade_in;
   logic                  fade_down_ff, fade_down_in;
   logic [LevelWidth-1:0] pend_r_ff, pend_r_in, pend_g_ff, pend_g_in, pend_b_ff, pend_b_in;
   logic                  red_tog_ff, red_tog_in, green_tog_ff, green_tog_in;
   logic [1:0]            phase_ff, phase_in;
   logic [LevelWidth-1:0] pin_r_ff, pin_r_in, pin_g_ff, pin_g_in, pin_b_ff, pin_b_in;

   logic [TimeWidth-1:0]   now_inc, sel_ts, elapsed;
   logic [PeriodWidth-1:0] sel_period;
   logic                   due, fade_dir;
   logic [LevelWidth-1:0]  fade_step;

   assign now_inc = now_ff + 32'd1;

   // Pick the timestamp and period the current mode runs on
   always_comb begin
      case (mode_ff)
         MODE_YELLOW, MODE_BLUE: begin
            sel_ts     = pulse_ts_ff;
            sel_period = cfg.pulse_period;
         end
         MODE_CYCLE: begin
            sel_ts     = cycle_ts_ff;
            sel_period = cfg.cycle_period;
         end
         default: begin
            sel_ts     = flash_ts_ff;
            sel_period = cfg.flash_period;
         end
      endcase
   end

   assign elapsed   = now_inc - sel_ts;
   assign due       = elapsed >= {16'd0, sel_period};
   assign fade_dir  = fade_down_ff ^ ((fade_ff == LevelOff) || (fade_ff == LevelMax));
   assign fade_step = fade_dir ? fade_ff - 8'd1 : fade_ff + 8'd1;

   always_comb begin
      now_in       = now_ff;
      pulse_ts_in  = pulse_ts_ff;
      flash_ts_in  = flash_ts_ff;
      cycle_ts_in  = cycle_ts_ff;
      mode_in      = mode_ff;
      fade_in      = fade_ff;
      fade_down_in = fade_down_ff;
      pend_r_in    = pend_r_ff;
      pend_g_in    = pend_g_ff;
      pend_b_in    = pend_b_ff;
      red_tog_in   = red_tog_ff;
      green_tog_in = green_tog_ff;
      phase_in     = phase_ff;
      pin_r_in     = pin_r_ff;
      pin_g_in     = pin_g_ff;
      pin_b_in     = pin_b_ff;
      if (step) begin
         if (req.action == ACT_TICK) begin
            now_in = now_inc;
            if (due) begin
               case (mode_ff)
                  MODE_YELLOW: begin
                     pulse_ts_in  = now_inc;
                     fade_down_in = fade_dir;
                     fade_in      = fade_step;
                     pin_r_in     = pend_r_ff;
                     pin_g_in     = pend_g_ff;
                     pin_b_in     = LevelOff;
                     pend_r_in    = fade_step;
                     pend_g_in    = green_of(fade_step);
                  end
                  MODE_BLUE: begin
                     pulse_ts_in  = now_inc;
                     fade_down_in = fade_dir;
                     fade_in      = fade_step;
                     pin_r_in     = LevelOff;
                     pin_g_in     = LevelOff;
                     pin_b_in     = pend_b_ff;
                     pend_b_in    = fade_step;
                  end
                  MODE_POLICE: begin
                     flash_ts_in = now_inc;
                     pin_r_in    = red_tog_ff ? LevelMax : LevelOff;
                     pin_g_in    = LevelOff;
                     pin_b_in    = red_tog_ff ? LevelOff : LevelMax;
                     red_tog_in  = !red_tog_ff;
                  end
                  MODE_RED: begin
                     flash_ts_in = now_inc;
                     red_tog_in  = !red_tog_ff;
                     pin_r_in    = red_tog_ff ? LevelOff : LevelMax;
                     pin_g_in    = LevelOff;
                     pin_b_in    = LevelOff;
                  end
                  MODE_GREEN: begin
                     flash_ts_in  = now_inc;
                     green_tog_in = !green_tog_ff;
                     pin_r_in     = LevelOff;
                     pin_g_in     = green_tog_ff ? LevelOff : LevelMax;
                     pin_b_in     = LevelOff;
                  end
                  MODE_CYCLE: begin
                     cycle_ts_in = now_inc;
                     pin_r_in    = (phase_ff == 2'd0) ? LevelMax : LevelOff;
                     pin_g_in    = (phase_ff == 2'd1) ? LevelMax : LevelOff;
                     pin_b_in    = (phase_ff[1])     ? LevelMax : LevelOff;
                     // stray phase 3 shows blue like phase 2
                     phase_in    = phase_ff[1] ? 2'd0 : phase_ff + 2'd1;
                  end
                  default: begin
                  end
               endcase
            end
         end else if ((req.new_mode <= MODE_CYCLE) && (req.new_mode != mode_ff)) begin
            mode_in      = mode_type'(req.new_mode);
            fade_in      = 8'd1;
            fade_down_in = 1'b0;
            pend_r_in    = LevelOff;
            pend_g_in    = LevelOff;
            pend_b_in    = LevelOff;
            pulse_ts_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         pulse_ts_ff  <= '0;
         flash_ts_ff  <= '0;
         cycle_ts_ff  <= '0;
         mode_ff      <= MODE_YELLOW;
         fade_ff      <= 8'd1;
         fade_down_ff <= 1'b0;
         pend_r_ff    <= LevelOff;
         pend_g_ff    <= LevelOff;
         pend_b_ff    <= LevelOff;
         red_tog_ff   <= 1'b0;
         green_tog_ff <= 1'b0;
         phase_ff     <= 2'd0;
         pin_r_ff     <= LevelOff;
         pin_g_ff     <= LevelOff;
         pin_b_ff     <= LevelOff;
      end else begin
         now_ff       <= now_in;
         pulse_ts_ff  <= pulse_ts_in;
         flash_ts_ff  <= flash_ts_in;
         cycle_ts_ff  <= cycle_ts_in;
         mode_ff      <= mode_in;
         fade_ff      <= fade_in;
         fade_down_ff <= fade_down_in;
         pend_r_ff    <= pend_r_in;
         pend_g_ff    <= pend_g_in;
         pend_b_ff    <= pend_b_in;
         red_tog_ff   <= red_tog_in;
         green_tog_ff <= green_tog_in;
         phase_ff     <= phase_in;
         pin_r_ff     <= pin_r_in;
         pin_g_ff     <= pin_g_in;
         pin_b_ff     <= pin_b_in;
      end
   end

   assign result.red_level   = pin_r_in;
   assign result.green_level = pin_g_in;
   assign result.blue_level  = pin_b_in;
   assign result.mode_now    = mode_in;

endmodule

// ===== hw/rtl/rgb_led_pattern_generator_core.sv =====
// Top level of the RGB LED pattern generator: request register, period
// registers and response register around rlpg_engine. Depends on rlpg_pkg.
//
//   channel   direction  payload                 accepted when
//   req_*     in         action, new_mode        req_valid  && req_ready
//   rsp_*     out        r/g/b levels, mode_now  rsp_valid  && rsp_ready
//   csr_*     in         index, 16-bit period    csr_valid  && csr_ready (always ready)
//
// Each request passes from the request register into the response register;
// the pattern logic between them is one 32-bit subtract-and-compare plus a
// small 8x16 multiply for green. Sustained rate is one request per cycle
// while rsp_ready stays high. A stalled response holds the
// response register and the request register behind it; req_ready drops
// only when both are full. Synchronous reset clears all control state,
// the pattern state and the period registers to their defaults.
module rgb_led_pattern_generator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rlpg_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rlpg_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rlpg_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [rlpg_pkg::PeriodWidth-1:0]      csr_data
);
   import rlpg_pkg::*;

   // Request stage
   req_type in_data_ff;
   logic    in_vld_ff, in_vld_in;

   // Response stage
   rsp_type rsp_data_ff;
   logic    rsp_vld_ff, rsp_vld_in;

   // Period registers
   cfg_type cfg_ff, cfg_in;

   rsp_type step_result;
   logic    advance;

   // Move the held request into the response register whenever that
   // register is empty or is being drained this cycle.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Register writes; an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PULSE_PERIOD: cfg_in.pulse_period = csr_data;
            CSR_FLASH_PERIOD: cfg_in.flash_period = csr_data;
            CSR_CYCLE_PERIOD: cfg_in.cycle_period = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff           <= 1'b0;
         rsp_vld_ff          <= 1'b0;
         cfg_ff.pulse_period <= PulsePeriodReset;
         cfg_ff.flash_period <= FlashPeriodReset;
         cfg_ff.cycle_period <= CyclePeriodReset;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         cfg_ff     <= cfg_in;
      end
   end

   // Payload registers: load on handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   rlpg_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .req    (in_data_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for rgb_led_pattern_generator_core: a directed
// table, then random request streams, checked against a built-in predictor.
// Depends on rlpg_pkg and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rlpg_pkg::*;

   // Codes outside the package enums: reserved modes and the unmapped register
   localparam logic [2:0] ModeReserved6 = 3'd6;
   localparam logic [2:0] ModeReserved7 = 3'd7;
   localparam logic [CsrIdxWidth-1:0] CsrUnmapped = 2'd3;

   // The pipe is a request register then a response register; DrainCycles lets it settle
   localparam int DrainCycles = 8;

   localparam rsp_type DarkYellow = '{LevelOff, LevelOff, LevelOff, MODE_YELLOW};
   localparam rsp_type Unchecked  = '0;

   typedef struct packed {
      req_type stim;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   localparam int DirCount    = 25;
   localparam int DirFastFrom = 4;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [PeriodWidth-1:0] csr_data  = '0;

   // Directed table. Rows 0..3 run at reset periods and carry typed results;
   // all periods drop to one before row DirFastFrom so every mode acts quickly.
   dir_row_type dir_rows [DirCount] = '{
      '{'{ACT_TICK, MODE_YELLOW},   1'b1, DarkYellow},
      '{'{ACT_MODE, ModeReserved6}, 1'b1, DarkYellow},
      '{'{ACT_MODE, ModeReserved7}, 1'b1, DarkYellow},
      '{'{ACT_MODE, MODE_YELLOW},   1'b1, DarkYellow},
      '{'{ACT_TICK, MODE_YELLOW},   1'b0, Unchecked},
      '{'{ACT_TICK, ModeReserved6}, 1'b0, Unchecked},
      '{'{ACT_MODE, MODE_POLICE},   1'b0, Unchecked},
      '{'{ACT_TICK, MODE_POLICE},   1'b0, Unchecked},
      '{'{ACT_TICK, ModeReserved7}, 1'b0, Unchecked},
      '{'{ACT_MODE, MODE_RED},      1'b0, Unchecked},
      '{'{ACT_TICK, MODE_RED},      1'b0, Unchecked},
      '{'{ACT_TICK, MODE_CYCLE},    1'b0, Unchecked},
      '{'{ACT_MODE, MODE_GREEN},    1'b0, Unchecked},
      '{'{ACT_TICK, MODE_GREEN},    1'b0, Unchecked},
      '{'{ACT_TICK, MODE_BLUE},     1'b0, Unchecked},
      '{'{ACT_MODE, MODE_BLUE},     1'b0, Unchecked},
      '{'{ACT_TICK, MODE_BLUE},     1'b0, Unchecked},
      '{'{ACT_TICK, MODE_POLICE},   1'b0, Unchecked},
      '{'{ACT_TICK, MODE_YELLOW},   1'b0, Unchecked},
      '{'{ACT_MODE, MODE_CYCLE},    1'b0, Unchecked},
      '{'{ACT_TICK, MODE_CYCLE},    1'b0, Unchecked},
      '{'{ACT_TICK, MODE_RED},      1'b0, Unchecked},
      '{'{ACT_TICK, MODE_GREEN},    1'b0, Unchecked},
      '{'{ACT_TICK, ModeReserved7}, 1'b0, Unchecked},
      '{'{ACT_MODE, MODE_YELLOW},   1'b0, Unchecked}
   };

   // Expected LED levels, oldest first, one per accepted request
   rsp_type levels_due [$];
   int      error_count = 0;
   int      rsp_seen    = 0;
   int      burst_left  = 0;

   // Predictor copy of the period registers and the pattern state
   logic [PeriodWidth-1:0] per_pulse = PulsePeriodReset;
   logic [PeriodWidth-1:0] per_flash = FlashPeriodReset;
   logic [PeriodWidth-1:0] per_cycle = CyclePeriodReset;

   logic [TimeWidth-1:0]  pat_now      = '0;
   logic [TimeWidth-1:0]  pat_pulse_at = '0;
   logic [TimeWidth-1:0]  pat_flash_at = '0;
   logic [TimeWidth-1:0]  pat_cycle_at = '0;
   mode_type              pat_mode     = MODE_YELLOW;
   logic [LevelWidth-1:0] pat_fade     = 8'd1;
   logic                  pat_fade_down = 1'b0;
   logic [LevelWidth-1:0] next_r = '0, next_g = '0, next_b = '0;
   logic [LevelWidth-1:0] pin_r = '0, pin_g = '0, pin_b = '0;
   logic                  red_tgl   = 1'b0;
   logic                  green_tgl = 1'b0;
   logic [1:0]            pat_phase = '0;

   rgb_led_pattern_generator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run
   initial begin
      #10ms;
      $display("rgb_led_pattern_generator_core test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Period check with wrapping time: the difference is never negative
   function automatic bit elapsed(logic [TimeWidth-1:0] stamp, logic [PeriodWidth-1:0] period);
      logic [TimeWidth-1:0] diff;
      diff = pat_now - stamp;
      return diff >= {16'd0, period};
   endfunction

   // Reverse at either end, then move the brightness by one
   function automatic void step_fade();
      if (pat_fade == LevelOff || pat_fade == LevelMax)
         pat_fade_down = !pat_fade_down;
      pat_fade = pat_fade_down ? pat_fade - 8'd1 : pat_fade + 8'd1;
   endfunction

   function automatic void show(logic [LevelWidth-1:0] r, g, b);
      pin_r = r;
      pin_g = g;
      pin_b = b;
   endfunction

   // Advance the pattern state by one request and return the levels it shows
   function automatic rsp_type next_levels(req_type r);
      rsp_type o;
      if (r.action == ACT_TICK) begin
         pat_now = pat_now + 1;
         case (pat_mode)
            MODE_YELLOW, MODE_BLUE: begin
               if (elapsed(pat_pulse_at, per_pulse)) begin
                  pat_pulse_at = pat_now;
                  step_fade();
                  // Breathing shows the levels worked out one step earlier
                  if (pat_mode == MODE_YELLOW) begin
                     show(next_r, next_g, LevelOff);
                     next_r = pat_fade;
                     next_g = 8'((32'(pat_fade) * 17) / 20);
                  end else begin
                     show(LevelOff, LevelOff, next_b);
                     next_b = pat_fade;
                  end
               end
            end
            MODE_POLICE: begin
               if (elapsed(pat_flash_at, per_flash)) begin
                  pat_flash_at = pat_now;
                  if (red_tgl) show(LevelMax, LevelOff, LevelOff);
                  else         show(LevelOff, LevelOff, LevelMax);
                  red_tgl = !red_tgl;
               end
            end
            MODE_RED: begin
               if (elapsed(pat_flash_at, per_flash)) begin
                  pat_flash_at = pat_now;
                  red_tgl = !red_tgl;
                  show(red_tgl ? LevelMax : LevelOff, LevelOff, LevelOff);
               end
            end
            MODE_GREEN: begin
               if (elapsed(pat_flash_at, per_flash)) begin
                  pat_flash_at = pat_now;
                  green_tgl = !green_tgl;
                  show(LevelOff, green_tgl ? LevelMax : LevelOff, LevelOff);
               end
            end
            MODE_CYCLE: begin
               if (elapsed(pat_cycle_at, per_cycle)) begin
                  pat_cycle_at = pat_now;
                  if (pat_phase == 2'd0) begin
                     show(LevelMax, LevelOff, LevelOff);
                     pat_phase = 2'd1;
                  end else if (pat_phase == 2'd1) begin
                     show(LevelOff, LevelMax, LevelOff);
                     pat_phase = 2'd2;
                  end else begin
                     show(LevelOff, LevelOff, LevelMax);
                     pat_phase = 2'd0;
                  end
               end
            end
            default: ;
         endcase
      end else if (r.new_mode <= MODE_CYCLE && r.new_mode != pat_mode) begin
         // Real mode change: restart breathing, keep flash and cycle state
         pat_mode      = mode_type'(r.new_mode);
         pat_fade      = 8'd1;
         pat_fade_down = 1'b0;
         next_r        = LevelOff;
         next_g        = LevelOff;
         next_b        = LevelOff;
         pat_pulse_at  = '0;
      end
      o.red_level   = pin_r;
      o.green_level = pin_g;
      o.blue_level  = pin_b;
      o.mode_now    = pat_mode;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Drive one request and hold it until accepted. Between bursts drop
   // valid for a random gap (sometimes none); inside a burst keep valid high back to back.
   task automatic push_request(req_type r, logic typed, rsp_type want);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted = next_levels(r);
      levels_due.push_back(typed ? want : predicted);
      burst_left--;
   endtask

   // Drop valid and wait until every outstanding request has answered
   task automatic halt_requests();
      req_valid <= 1'b0;
      burst_left = 0;
      while (levels_due.size() != 0) @(posedge clock);
   endtask

   // Write all three periods, then junk into the unmapped index.
   // Only call while the block is idle.
   task automatic load_periods(logic [PeriodWidth-1:0] p, f, c);
      logic [CsrIdxWidth-1:0] idx [4];
      logic [PeriodWidth-1:0] val [4];
      idx[0] = CSR_PULSE_PERIOD;
      idx[1] = CSR_FLASH_PERIOD;
      idx[2] = CSR_CYCLE_PERIOD;
      idx[3] = CsrUnmapped;
      val[0] = p;
      val[1] = f;
      val[2] = c;
      val[3] = 16'($urandom);
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         do @(posedge clock); while (!csr_ready);
         case (idx[k])
            CSR_PULSE_PERIOD: per_pulse = val[k];
            CSR_FLASH_PERIOD: per_flash = val[k];
            CSR_CYCLE_PERIOD: per_cycle = val[k];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // One random phase. A breathing phase parks the block in yellow and only
   // sends requests that leave the fade running, so it sweeps both ends.
   task automatic run_phase(logic [PeriodWidth-1:0] p, f, c, int count, bit breathing);
      req_type r;
      halt_requests();
      load_periods(p, f, c);
      if (breathing)
         push_request('{action: ACT_MODE, new_mode: MODE_YELLOW}, 1'b0, Unchecked);
      repeat (count) begin
         r.new_mode = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 99) < (breathing ? 95 : 75)) begin
            r.action = ACT_TICK;
         end else begin
            r.action = ACT_MODE;
            if (breathing) begin
               case ($urandom_range(0, 2))
                  0:       r.new_mode = MODE_YELLOW;
                  1:       r.new_mode = ModeReserved6;
                  default: r.new_mode = ModeReserved7;
               endcase
            end
         end
         push_request(r, 1'b0, Unchecked);
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: reset periods first, then everything at period one
      for (int i = 0; i < DirCount; i++) begin
         if (i == DirFastFrom) begin
            halt_requests();
            load_periods(16'd1, 16'd1, 16'd1);
         end
         push_request(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
      end

      // Long breathing sweep, then zero, largest and small random periods
      run_phase(16'd1, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 560, 1'b1);
      run_phase(16'd0, 16'd0, 16'd0, 60, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 40, 1'b0);
      run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 8)), 70, 1'b0);
      run_phase(16'($urandom_range(1, 16)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 4)), 70, 1'b0);

      // Drain, let the pipe settle, then judge
      halt_requests();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && levels_due.size() == 0)
         $display("rgb_led_pattern_generator_core test passed");
      else
         $display("rgb_led_pattern_generator_core test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Stall on windows of random length, each with its own stall density;
   // a zero density gives stretches with no back-pressure at all
   initial begin : rsp_stall
      int window;
      int stall_pct;
      window    = 0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if (window == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               2:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
            window = $urandom_range(16, 96);
         end
         window--;
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic report_mismatch(string msg);
      $display("[%0t] response %0d: %s", $realtime, rsp_seen, msg);
      error_count++;
   endtask

   // Compare each accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (levels_due.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = levels_due.pop_front();
            if (rsp_data.red_level !== want.red_level)
               report_mismatch($sformatf("red_level %0d, expected %0d",
                                         rsp_data.red_level, want.red_level));
            if (rsp_data.green_level !== want.green_level)
               report_mismatch($sformatf("green_level %0d, expected %0d",
                                         rsp_data.green_level, want.green_level));
            if (rsp_data.blue_level !== want.blue_level)
               report_mismatch($sformatf("blue_level %0d, expected %0d",
                                         rsp_data.blue_level, want.blue_level));
            if (rsp_data.mode_now !== want.mode_now)
               report_mismatch($sformatf("mode_now %0d, expected %0d",
                                         rsp_data.mode_now, want.mode_now));
         end
         rsp_seen++;
      end
   end

endmodule

// ===== sim.f =====
hw/rtl/rlpg_pkg.sv
hw/rtl/rlpg_engine.sv
hw/rtl/rgb_led_pattern_generator_core.sv
dv/testbench.sv
